/* hdl/lwfr_pkg.sv */
`default_nettype none

package lwfr_pkg;

  // Pipeline depth from an accepted input beat to its output beat.
  localparam int unsigned FRONT_LAT = 4;
  localparam int unsigned EXP_LAT   = 5;
  localparam int unsigned MUL_LAT   = 3;
  localparam int unsigned PIPE_LAT  = FRONT_LAT + EXP_LAT + MUL_LAT;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_Y = 2'd2;

  localparam logic [15:0] SCALE_RST   = 16'd256;
  localparam logic [15:0] SIGMA_X_RST = 16'd4096;
  localparam logic [15:0] SIGMA_Y_RST = 16'd4096;

  typedef struct packed {
    logic [15:0] scale;
    logic [15:0] sigma_x;
    logic [15:0] sigma_y;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/lwfr_front.sv */
`default_nettype none

module lwfr_front (
  input  wire  logic                clk_i,
  input  wire  logic                en_i,
  input  wire  lwfr_pkg::cfg_t      cfg_i,
  input  wire  logic signed [15:0]  freq_x_i,
  input  wire  logic signed [15:0]  freq_y_i,
  output logic [29:0]               arg_o,
  output logic                      under_o,
  output logic [47:0]               ms_lo_o,
  output logic [46:0]               ms_hi_o
);
  import lwfr_pkg::*;

  logic [15:0] mag_x, mag_y;
  logic [31:0] ux_full, uy_full;
  logic [30:0] ux_d, uy_d, ux_q, uy_q;

  logic [61:0] u2_d, v2_d, u2_q, v2_q;
  logic [46:0] px_full, py_full;
  logic [30:0] px_q, py_q;

  logic [62:0] m_d, m_q;
  logic [61:0] hx_full, hy_full;
  logic [60:0] hx_q, hy_q;

  logic [61:0] a_sum;
  logic [29:0] arg_q;
  logic        under_q;
  logic [47:0] ms_lo_d, ms_lo_q;
  logic [46:0] ms_hi_d, ms_hi_q;

  // Stage 1: magnitudes scaled into Q.20.
  assign mag_x   = freq_x_i[15] ? (~freq_x_i + 16'd1) : freq_x_i;
  assign mag_y   = freq_y_i[15] ? (~freq_y_i + 16'd1) : freq_y_i;
  assign ux_full = cfg_i.scale * mag_x;
  assign uy_full = cfg_i.scale * mag_y;
  assign ux_d    = ux_full[30:0];
  assign uy_d    = uy_full[30:0];

  // Stage 2: squares for the magnitude term and sigma-weighted terms.
  assign u2_d    = ux_q * ux_q;
  assign v2_d    = uy_q * uy_q;
  assign px_full = cfg_i.sigma_x * ux_q;
  assign py_full = cfg_i.sigma_y * uy_q;

  // Stage 3: sum of squares and halved exponent terms.
  assign m_d     = {1'b0, u2_q} + {1'b0, v2_q};
  assign hx_full = px_q * px_q;
  assign hy_full = py_q * py_q;

  // Stage 4: exponent argument and the scale product split in two halves.
  assign a_sum   = {1'b0, hx_q} + {1'b0, hy_q};
  assign ms_lo_d = m_q[31:0] * cfg_i.scale;
  assign ms_hi_d = m_q[62:32] * cfg_i.scale;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q    <= ux_d;
      uy_q    <= uy_d;
      u2_q    <= u2_d;
      v2_q    <= v2_d;
      px_q    <= px_full[46:16];
      py_q    <= py_full[46:16];
      m_q     <= m_d;
      hx_q    <= hx_full[61:1];
      hy_q    <= hy_full[61:1];
      arg_q   <= a_sum[37:8];
      under_q <= |a_sum[61:38];
      ms_lo_q <= ms_lo_d;
      ms_hi_q <= ms_hi_d;
    end
  end

  assign arg_o   = arg_q;
  assign under_o = under_q;
  assign ms_lo_o = ms_lo_q;
  assign ms_hi_o = ms_hi_q;

endmodule

`default_nettype wire

/* hdl/lwfr_exp.sv */
`default_nettype none

module lwfr_exp #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  wire  logic        clk_i,
  input  wire  logic        en_i,
  input  wire  logic [29:0] arg_i,
  input  wire  logic        under_i,
  output logic [31:0]       e_o
);
  import lwfr_pkg::*;

  localparam logic [31:0] LN2_Q31   = 32'd1488522236;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;

  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DW    = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned TW    = 24 + DW;
  localparam logic [DW-1:0] DEPTH_C = DW'(EXP_TABLE_DEPTH);

  // 2^(-i/D) in Q1.31 from a truncated Taylor series of exp(-i*ln2/D).
  function automatic logic [31:0] exp_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    int unsigned n;
    x    = (64'(idx) * 64'(LN2_Q31)) / 64'(EXP_TABLE_DEPTH);
    term = 64'(ONE_Q31);
    pos  = term;
    neg  = 64'd0;
    for (n = 1; n <= 30; n++) begin
      if (term != 64'd0) begin
        term = ((term * x) >> 31) / 64'(n);
        if (n[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    return (pos > neg) ? 32'(pos - neg) : 32'd0;
  endfunction

  logic [31:0] tab [EXP_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
    localparam logic [31:0] TAB_VAL = exp_entry(gi);
    assign tab[gi] = TAB_VAL;
  end

  logic [60:0]   b_full;
  logic [30:0]   b_q;
  logic          z1_q, z2_q, z3_q, z4_q;
  logic [TW-1:0] t_d, t_q;
  logic [4:0]    k2_q, k3_q, k4_q;
  logic [DW-1:0] idx_lo, idx_hi;
  logic [31:0]   lo3_q, hi3_q, lo4_q;
  logic [23:0]   r3_q;
  logic [55:0]   corr_full;
  logic [31:0]   corr_q;
  logic          ge_q;
  logic [31:0]   e_lin, e_d, e_q;

  // Stage 1: convert to base 2, Q.24.
  assign b_full = arg_i * LOG2E_Q30;

  // Stage 2: fractional part scaled to table positions.
  assign t_d = b_q[23:0] * DEPTH_C;

  // Stage 3: table reads at both neighbors.
  assign idx_lo = DW'(t_q[24 +: IDX_W]);
  assign idx_hi = idx_lo + DW'(1);

  // Stage 4: interpolation correction.
  assign corr_full = (lo3_q - hi3_q) * r3_q;

  // Stage 5: apply correction and the integer shift.
  assign e_lin = ge_q ? (lo4_q - corr_q) : lo4_q;
  assign e_d   = z4_q ? 32'd0 : (e_lin >> k4_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q    <= b_full[60:30];
      z1_q   <= under_i;
      // An integer part of 32 or more shifts everything out.
      z2_q   <= z1_q | (|b_q[30:29]);
      k2_q   <= b_q[28:24];
      t_q    <= t_d;
      z3_q   <= z2_q;
      k3_q   <= k2_q;
      lo3_q  <= tab[idx_lo];
      hi3_q  <= tab[idx_hi];
      r3_q   <= t_q[23:0];
      z4_q   <= z3_q;
      k4_q   <= k3_q;
      lo4_q  <= lo3_q;
      ge_q   <= lo3_q >= hi3_q;
      corr_q <= corr_full[55:24];
      e_q    <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

`default_nettype wire

/* hdl/lwfr_mul.sv */
`default_nettype none

module lwfr_mul (
  input  wire  logic        clk_i,
  input  wire  logic        en_i,
  input  wire  logic [47:0] ms_lo_i,
  input  wire  logic [46:0] ms_hi_i,
  input  wire  logic [31:0] e_i,
  output logic [31:0]       response_o,
  output logic              saturated_o
);
  import lwfr_pkg::*;

  localparam int unsigned MS_DLY = EXP_LAT;

  logic [78:0]  ms_d;
  logic [78:0]  ms_q [MS_DLY];
  logic [63:0]  pp0_d, pp1_d, pp0_q, pp1_q;
  logic [46:0]  pp2_d, pp2_q, pp2b_q;
  logic [95:0]  s01_d, s01_q;
  logic [110:0] tot;
  logic         sat_d, sat_q;
  logic [31:0]  resp_d, resp_q;

  assign ms_d = {31'd0, ms_lo_i} + {ms_hi_i, 32'd0};

  // Partial products of the 79-bit scale product with the exponential.
  assign pp0_d = ms_q[MS_DLY-1][31:0] * e_i;
  assign pp1_d = ms_q[MS_DLY-1][63:32] * e_i;
  assign pp2_d = ms_q[MS_DLY-1][78:64] * e_i;

  assign s01_d = {32'd0, pp0_q} + {pp1_q, 32'd0};

  // The result is the product divided by 2^63; anything at 2^95 or above clips.
  assign tot    = {15'd0, s01_q} + {pp2b_q, 64'd0};
  assign sat_d  = |tot[110:95];
  assign resp_d = sat_d ? 32'hFFFF_FFFF : tot[94:63];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ms_q[0] <= ms_d;
      for (int i = 1; i < MS_DLY; i++) begin
        ms_q[i] <= ms_q[i-1];
      end
      pp0_q  <= pp0_d;
      pp1_q  <= pp1_d;
      pp2_q  <= pp2_d;
      s01_q  <= s01_d;
      pp2b_q <= pp2_q;
      sat_q  <= sat_d;
      resp_q <= resp_d;
    end
  end

  assign response_o  = resp_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

/* hdl/log_wavelet_frequency_response_top.sv */
// Throughput: one beat per cycle unless the output is held; the four-stage
// front end, five-stage exponential unit and three-stage final multiplier
// are fully pipelined.
// A stalled output freezes every stage together, so nothing is lost or repeated.
// Reset clears the valid bits and loads scale 1.0 and both sigmas 1.0.
`default_nettype none

module log_wavelet_frequency_response_top #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  wire  logic                            clk_i,
  input  wire  logic                            rst_ni,
  input  wire  logic                            s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  logic [31:0]                     s_axis_tdata,  // freq_x, freq_y
  output logic                                  m_axis_tvalid,
  input  wire  logic                            m_axis_tready,
  output logic [31:0]                           m_axis_tdata,  // response
  output logic [0:0]                            m_axis_tuser,  // saturated
  input  wire  logic                            cfg_we_i,
  input  wire  logic [lwfr_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire  logic [15:0]                     cfg_wdata_i
);
  import lwfr_pkg::*;

  cfg_t                cfg_q;
  logic [PIPE_LAT-1:0] vld_d, vld_q;
  logic                en;

  logic [29:0] arg;
  logic        under;
  logic [47:0] ms_lo;
  logic [46:0] ms_hi;
  logic [31:0] e_val;
  logic [31:0] response;
  logic        saturated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale   <= SCALE_RST;
      cfg_q.sigma_x <= SIGMA_X_RST;
      cfg_q.sigma_y <= SIGMA_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SCALE:   cfg_q.scale   <= cfg_wdata_i;
        REG_SIGMA_X: cfg_q.sigma_x <= cfg_wdata_i;
        REG_SIGMA_Y: cfg_q.sigma_y <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output beat is held.
  assign en    = !vld_q[PIPE_LAT-1] || m_axis_tready;
  assign vld_d = {vld_q[PIPE_LAT-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  lwfr_front u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .freq_x_i (s_axis_tdata[15:0]),
    .freq_y_i (s_axis_tdata[31:16]),
    .arg_o    (arg),
    .under_o  (under),
    .ms_lo_o  (ms_lo),
    .ms_hi_o  (ms_hi)
  );

  lwfr_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk_i   (clk_i),
    .en_i    (en),
    .arg_i   (arg),
    .under_i (under),
    .e_o     (e_val)
  );

  lwfr_mul u_mul (
    .clk_i       (clk_i),
    .en_i        (en),
    .ms_lo_i     (ms_lo),
    .ms_hi_i     (ms_hi),
    .e_i         (e_val),
    .response_o  (response),
    .saturated_o (saturated)
  );

  assign s_axis_tready   = en;
  assign m_axis_tvalid   = vld_q[PIPE_LAT-1];
  assign m_axis_tdata    = response;
  assign m_axis_tuser[0] = saturated;

`ifndef ASSERT_OFF
  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'hFFFF_FFFF)
    else $error("saturated beat without full-scale response");

  a_valid_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |=> vld_q[1] == $past(vld_q[0]))
    else $error("valid bit lost or duplicated in the pipeline");

  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved while the output was held");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the output beat is stalled");
`endif

endmodule

`default_nettype wire
